>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/spmv_pkg.sv
`timescale 1ns / 1ps

package spmv_pkg;

  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);

  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int ROW_W  = 16;
  localparam int ACC_W  = 64;
  localparam int FRAC_W = 16;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_MAC   = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam logic REG_ROW_COUNT = 1'b0;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] row_sum;
    logic                    last_row;
    logic                    saturated;
  } res_t;

endpackage

>>> rtl/core/spmv_ram.sv
`timescale 1ns / 1ps

module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/csr_sparse_matrix_vector_multiply_top.sv
`timescale 1ns / 1ps

// Sparse matrix times dense vector for a matrix streamed in compressed-row form.
// Mode 0 words load the vector store, mode 1 words carry one nonzero and its
// column, mode 2 words close a row and produce one result word. One input word
// is taken every clock cycle unless the input stalls: the vector store is a RAM
// with one write and one registered read port, followed by a registered 32x32
// multiply and a 64-bit saturating accumulate; a close word passes through the
// s1 and s2 stages before its row result enters the output buffer. Up to four
// row results are buffered; the input stalls only while four results are
// outstanding. Vector entries must be written before they are read.
module csr_sparse_matrix_vector_multiply_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic [spmv_pkg::IDX_W-1:0]          index_i,
  input  logic signed [spmv_pkg::VAL_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [spmv_pkg::ROW_W-1:0]          row_o,
  output logic signed [spmv_pkg::VAL_W-1:0]   row_sum_o,
  output logic                                last_row_o,
  output logic                                saturated_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spmv_pkg::APB_AW-1:0]         paddr,
  input  logic [spmv_pkg::APB_DW-1:0]         pwdata,
  output logic [spmv_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import spmv_pkg::*;

  `include "assert_macros.svh"

  logic               in_fire;
  logic               in_range;
  logic               ram_we;
  logic               ram_re;
  logic [VAL_W-1:0]   ram_rdata;

  logic               s1_mac_q;
  logic               s1_close_q;
  logic [VAL_W-1:0]   s1_val_q;
  logic               s2_mac_q;
  logic               s2_close_q;
  logic signed [ACC_W-1:0] s2_prod_q;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [ACC_W:0]     sum;
  logic               sum_ovf;

  logic [ROW_W-1:0]   row_q, row_d;
  logic [ROW_W-1:0]   row_count_q;
  logic               last;
  logic [ACC_W-FRAC_W-1:0] shifted;
  logic               fits;
  res_t               res;

  res_t               fifo_q [OUT_DEPTH];
  logic [OUT_AW-1:0]  wr_ptr_q;
  logic [OUT_AW-1:0]  rd_ptr_q;
  logic [OUT_CW-1:0]  fifo_cnt_q;
  logic [OUT_CW-1:0]  cred_q;
  logic               push;
  logic               pop;
  logic               close_in;
  logic               cfg_we;

  assign in_ready_o = cred_q != OUT_CW'(OUT_DEPTH);
  assign in_fire    = in_valid_i & in_ready_o;
  assign in_range   = 32'(index_i) < VEC_DEPTH;
  assign ram_we     = in_fire && mode_i == MODE_LOAD && in_range;
  assign ram_re     = in_fire && mode_i == MODE_MAC && in_range;
  assign close_in   = in_fire && mode_i == MODE_CLOSE;

  spmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (VEC_AW'(index_i)),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (VEC_AW'(index_i)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mac_q   <= 1'b0;
      s1_close_q <= 1'b0;
      s2_mac_q   <= 1'b0;
      s2_close_q <= 1'b0;
    end else begin
      s1_mac_q   <= ram_re;
      s1_close_q <= close_in;
      s2_mac_q   <= s1_mac_q;
      s2_close_q <= s1_close_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_val_q  <= value_i;
    s2_prod_q <= ACC_W'($signed(s1_val_q)) * ACC_W'($signed(ram_rdata));
  end

  assign sum     = {acc_q[ACC_W-1], acc_q} + {s2_prod_q[ACC_W-1], s2_prod_q};
  assign sum_ovf = sum[ACC_W] != sum[ACC_W-1];

  assign shifted = acc_q[ACC_W-1:FRAC_W];
  assign fits    = (&shifted[ACC_W-FRAC_W-1:VAL_W-1]) | ~(|shifted[ACC_W-FRAC_W-1:VAL_W-1]);
  assign last    = row_q >= (row_count_q - ROW_W'(1));

  always_comb begin
    res.row       = row_q;
    res.last_row  = last;
    res.saturated = ovf_q | ~fits;
    if (fits) begin
      res.row_sum = shifted[VAL_W-1:0];
    end else if (shifted[ACC_W-FRAC_W-1]) begin
      res.row_sum = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res.row_sum = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    row_d = row_q;
    if (s2_close_q) begin
      acc_d = '0;
      ovf_d = 1'b0;
      row_d = last ? '0 : row_q + ROW_W'(1);
    end else if (s2_mac_q) begin
      if (sum_ovf) begin
        acc_d = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        ovf_d = 1'b1;
      end else begin
        acc_d = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
      row_q <= '0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
      row_q <= row_d;
    end
  end

  assign push = s2_close_q;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      cred_q     <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + OUT_CW'(push) - OUT_CW'(pop);
      cred_q     <= cred_q + OUT_CW'(close_in) - OUT_CW'(pop);
    end
  end

  assign out_valid_o = fifo_cnt_q != '0;
  assign row_o       = fifo_q[rd_ptr_q].row;
  assign row_sum_o   = fifo_q[rd_ptr_q].row_sum;
  assign last_row_o  = fifo_q[rd_ptr_q].last_row;
  assign saturated_o = fifo_q[rd_ptr_q].saturated;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[APB_AW-1] == REG_ROW_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_W'(1);
    end else if (cfg_we) begin
      row_count_q <= pwdata[ROW_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1] == REG_ROW_COUNT) begin
      prdata = APB_DW'(row_count_q);
    end
  end

  `ASSERT_PROP(a_cred_bound, clk_i, rst_ni, cred_q <= OUT_CW'(OUT_DEPTH))
  `ASSERT_PROP(a_fifo_within_cred, clk_i, rst_ni, fifo_cnt_q <= cred_q)
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni,
                push && fifo_cnt_q == OUT_CW'(OUT_DEPTH) && !pop)
  `ASSERT_PROP(a_close_clears, clk_i, rst_ni,
               s2_close_q |=> (acc_q == '0 && !ovf_q))

endmodule

>>> sim/csr_sparse_matrix_vector_multiply_top_test.sv
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_top_test;
  import spmv_pkg::*;

  localparam logic [1:0] MODE_SKIP = 2'd3;
  localparam logic [APB_AW-1:0] ROW_COUNT_ADDR = APB_AW'(4 * int'(REG_ROW_COUNT));
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam int IDLE_PCT = 9;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 1200;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } word_t;

  typedef struct packed {
    word_t w;
    logic  known;
    res_t  res;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = MODE_LOAD;
  logic [IDX_W-1:0] index_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ROW_W-1:0] row_o;
  logic signed [VAL_W-1:0] row_sum_o;
  logic last_row_o;
  logic saturated_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  logic [VAL_W-1:0] vec_mem [VEC_DEPTH];
  bit vec_written [VEC_DEPTH];
  int loaded_idx [$];
  longint acc_q;
  bit acc_sat;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] row_count_q;

  step_t script [$];
  res_t row_sums_due [$];
  res_t want;
  int words_sent;
  int sums_checked;
  int mismatches;
  int settings_used;
  bit no_gaps;
  int hold_requests;
  int hold_served;
  int hold_left;

  csr_sparse_matrix_vector_multiply_top DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic bit spmv_apply(input word_t w, output res_t r);
    longint prod;
    logic [64:0] wide;
    longint q;
    int rows;
    r = '0;
    case (w.mode)
      MODE_LOAD: begin
        if (!vec_written[w.index]) loaded_idx.push_back(int'(w.index));
        vec_written[w.index] = 1'b1;
        vec_mem[w.index] = w.value;
      end
      MODE_MAC: begin
        prod = longint'($signed(w.value)) * longint'($signed(vec_mem[w.index]));
        wide = {acc_q[63], acc_q} + {prod[63], prod};
        if (wide[64] != wide[63]) begin
          acc_q = wide[64] ? ACC_MIN : ACC_MAX;
          acc_sat = 1'b1;
        end else begin
          acc_q = wide[63:0];
        end
      end
      MODE_CLOSE: begin
        rows = (row_count_q == '0) ? 65536 : int'(row_count_q);
        q = acc_q >>> FRAC_W;
        r.saturated = acc_sat;
        if (q > SUM_MAX) begin
          q = SUM_MAX;
          r.saturated = 1'b1;
        end else if (q < SUM_MIN) begin
          q = SUM_MIN;
          r.saturated = 1'b1;
        end
        r.row = cur_row;
        r.row_sum = q[VAL_W-1:0];
        r.last_row = int'(cur_row) >= rows - 1;
        cur_row = r.last_row ? '0 : cur_row + ROW_W'(1);
        acc_q = 0;
        acc_sat = 1'b0;
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4, 5: return VAL_W'(int'($urandom_range(262144)) - 131072);
      6, 7: return VAL_W'(int'($urandom_range(32'h0100_0000)) - 32'h0080_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_step(input logic [1:0] m, input int idx, input logic [31:0] v,
                                   input bit known = 1'b0, input logic [31:0] sum = '0,
                                   input bit sat = 1'b0);
    step_t s;
    s.w.mode = m;
    s.w.index = IDX_W'(idx);
    s.w.value = v;
    s.known = known;
    s.res.row = '0;
    s.res.row_sum = sum;
    s.res.last_row = 1'b1;
    s.res.saturated = sat;
    script.push_back(s);
  endfunction

  task automatic send_word(input word_t w, input bit known, input res_t known_res);
    res_t r;
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= w.mode;
    index_i <= w.index;
    value_i <= w.value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (w.mode != MODE_SKIP) words_sent++;
    if (spmv_apply(w, r)) row_sums_due.push_back(known ? known_res : r);
  endtask

  task automatic offer(input logic [1:0] m, input logic [IDX_W-1:0] idx,
                       input logic [VAL_W-1:0] v);
    word_t w;
    w.mode = m;
    w.index = idx;
    w.value = v;
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_row(input int len);
    repeat (len) begin
      if ($urandom_range(99) < 12) begin
        offer(MODE_LOAD, IDX_W'($urandom_range(VEC_DEPTH - 1)), pick_value());
      end
      offer(MODE_MAC, IDX_W'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]), pick_value());
    end
    offer(MODE_CLOSE, IDX_W'($urandom()), $urandom());
  endtask

  task automatic random_phase(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      case ($urandom_range(19))
        0: offer(MODE_SKIP, IDX_W'($urandom()), $urandom());
        1, 2: offer(MODE_LOAD, IDX_W'($urandom_range(VEC_DEPTH - 1)), pick_value());
        default: send_row(($urandom_range(19) == 0) ? $urandom_range(24) : $urandom_range(6));
      endcase
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_row_count(input logic [ROW_W-1:0] val);
    logic [APB_DW-1:0] rd;
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROW_COUNT_ADDR;
    pwdata <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    row_count_q = val;
    settings_used++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (rd[ROW_W-1:0] !== val) begin
      $display("%0t: row_count read back %h, expected %h", $time, rd[ROW_W-1:0], val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (row_sums_due.size() == 0) begin
        $display("%0t: unexpected row word, expected none, got row %0d sum %h last %b sat %b",
                 $time, row_o, row_sum_o, last_row_o, saturated_o);
        mismatches++;
      end else begin
        want = row_sums_due.pop_front();
        sums_checked++;
        if (row_o !== want.row || row_sum_o !== want.row_sum ||
            last_row_o !== want.last_row || saturated_o !== want.saturated) begin
          $display("%0t: row word expected row %0d sum %h last %b sat %b, got row %0d sum %h last %b sat %b",
                   $time, want.row, want.row_sum, want.last_row, want.saturated,
                   row_o, row_sum_o, last_row_o, saturated_o);
          mismatches++;
        end
      end
    end
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_gaps || $urandom_range(99) >= IDLE_PCT;
    end
  end

  initial begin
    acc_q = 0;
    acc_sat = 1'b0;
    cur_row = '0;
    row_count_q = 16'd1;

    add_step(MODE_CLOSE, 0, 32'h0, 1'b1, 32'h0000_0000, 1'b0);
    add_step(MODE_LOAD, 0, 32'h7FFF_FFFF);
    add_step(MODE_LOAD, VEC_DEPTH - 1, 32'h8000_0000);
    add_step(MODE_LOAD, 'h155, 32'h0001_0000);
    add_step(MODE_LOAD, 'h2AA, 32'hFFFF_0000);
    add_step(MODE_LOAD, 2, 32'h0000_0001);
    add_step(MODE_MAC, VEC_DEPTH - 1, 32'h8000_0000);
    add_step(MODE_MAC, VEC_DEPTH - 1, 32'h8000_0000);
    add_step(MODE_CLOSE, 0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1);
    add_step(MODE_MAC, VEC_DEPTH - 1, 32'h7FFF_FFFF);
    add_step(MODE_MAC, VEC_DEPTH - 1, 32'h7FFF_FFFF);
    add_step(MODE_MAC, VEC_DEPTH - 1, 32'h7FFF_FFFF);
    add_step(MODE_CLOSE, 0, 32'h0, 1'b1, 32'h8000_0000, 1'b1);
    add_step(MODE_MAC, 'h155, 32'h0001_8000);
    add_step(MODE_MAC, 'h2AA, 32'h0000_8000);
    add_step(MODE_CLOSE, 0, 32'h0);
    add_step(MODE_SKIP, 'h3FF, 32'hFFFF_FFFF);
    add_step(MODE_MAC, 2, 32'hFFFF_FFFF);
    add_step(MODE_CLOSE, 0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_step(MODE_MAC, 0, 32'h7FFF_FFFF);
    add_step(MODE_CLOSE, 0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1);
    add_step(MODE_LOAD, 3, 32'h0002_0000);
    add_step(MODE_MAC, 3, 32'h0003_0000);
    add_step(MODE_CLOSE, 0, 32'h0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send_word(script[i].w, script[i].known, script[i].res);

    repeat (24) offer(MODE_LOAD, IDX_W'($urandom_range(VEC_DEPTH - 1)), pick_value());
    set_row_count(16'd7);
    random_phase(150);
    while (cur_row != 16'd6) offer(MODE_CLOSE, '0, '0);
    // The current row now lies past the last row of the smaller matrix.
    set_row_count(16'd3);
    random_phase(100);
    hold_requests++;
    repeat (16) send_row($urandom_range(2));
    random_phase(60);
    set_row_count(16'hFFFF);
    no_gaps = 1'b1;
    random_phase(250);
    no_gaps = 1'b0;
    set_row_count(16'd0);
    random_phase(150);
    set_row_count(16'd1);
    random_phase(100);
    while (words_sent < RANDOM_WORDS + script.size()) begin
      set_row_count(16'($urandom_range(12, 2)));
      random_phase(120);
    end
    settle();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d vector and matrix words, checked %0d row sums over %0d row_count settings.",
             words_sent, sums_checked, settings_used);
    $display("Run included saturation, row wrap, ignored words, a long output stall and drains.");
    if (mismatches == 0) begin
      $display("csr_sparse_matrix_vector_multiply_top: match");
    end else begin
      $display("csr_sparse_matrix_vector_multiply_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d row sums still outstanding.", row_sums_due.size());
    $display("csr_sparse_matrix_vector_multiply_top: mismatch");
    $finish;
  end

endmodule
